[src/drt_pkg.sv]
// drt_pkg: shared types and constants for the dirty rectangle tracker.
// Used by drt_ctrl, drt_dp and the top level; no dependencies.
`default_nettype none
package drt_pkg;

  localparam int MERGES_W = 6;
  localparam int PEND_W   = 7;
  localparam int SIZE_W   = 13;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_FULL  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic {
    RSEL_I = 1'b0,
    RSEL_J = 1'b1
  } rsel_t;

  // command bundle from controller to datapath
  typedef struct packed {
    logic  append;     // write new rect at count, count++, arm pass
    logic  set_full;   // flag=1, count=0
    logic  clear;      // flag=0, count=0
    logic  flag_set;   // flag=1 only
    logic  i_clr;
    logic  i_inc;
    logic  acc_ld;     // acc <= read data, j <= i+1
    logic  j_inc;
    logic  rd;
    rsel_t rsel;
    logic  merge;      // compare read data with acc, merge if touching
    logic  wr_acc;     // write acc back to entry i
    logic  cp;         // compaction: move live entry i down to w
    logic  k_start;    // i=0, w=0
    logic  cnt_from_w;
    logic  out_stat;
    logic  out_full;
    logic  out_zero;
    logic  out_ent;
  } drt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic tbl_full;
    logic flag;
    logic cnt_zero;
    logic i_done;
    logic i_live;
    logic j_done;
    logic j_live;
    logic merges_nz;
    logic out_free;
    logic ent_last;
  } drt_stat_t;

endpackage
`default_nettype wire

[src/drt_ram.sv]
// drt_ram: generic RAM, one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module drt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[src/drt_ctrl.sv]
// drt_ctrl: sequencer for mark, merge pass, compaction and flush.
// Depends on drt_pkg; drives drt_dp through command and status structs.
`default_nettype none
module drt_ctrl import drt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_accept,
  input  wire drt_stat_t st,
  output drt_cmd_t       cmd,
  output logic           in_ready_r
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ICHK, S_ILD, S_JRD, S_JCMP, S_WRI,
    S_KRD, S_KCP, S_EMIT1, S_EMITF, S_EMITZ, S_FLRD, S_FLEM
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.rsel  = RSEL_I;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_DEC;
      S_DEC: begin
        case (st.op)
          OP_MARK: begin
            if (st.tbl_full) begin
              cmd.flag_set = 1'b1;
              state_nxt    = S_EMIT1;
            end else begin
              cmd.append = 1'b1;
              state_nxt  = S_ICHK;
            end
          end
          OP_FULL: begin
            cmd.set_full = 1'b1;
            state_nxt    = S_EMIT1;
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_EMIT1;
          end
          default: begin
            cmd.i_clr = 1'b1;
            if (st.flag)          state_nxt = S_EMITF;
            else if (st.cnt_zero) state_nxt = S_EMITZ;
            else                  state_nxt = S_FLRD;
          end
        endcase
      end
      S_ICHK: begin
        if (st.i_done) begin
          if (st.merges_nz) begin
            cmd.k_start = 1'b1;
            state_nxt   = S_KRD;
          end else begin
            state_nxt = S_EMIT1;
          end
        end else if (!st.i_live) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_ILD;
        end
      end
      S_ILD: begin
        cmd.acc_ld = 1'b1;
        state_nxt  = S_JRD;
      end
      S_JRD: begin
        if (st.j_done) begin
          state_nxt = S_WRI;
        end else if (!st.j_live) begin
          cmd.j_inc = 1'b1;
        end else begin
          cmd.rd    = 1'b1;
          cmd.rsel  = RSEL_J;
          state_nxt = S_JCMP;
        end
      end
      S_JCMP: begin
        cmd.merge = 1'b1;
        cmd.j_inc = 1'b1;
        state_nxt = S_JRD;
      end
      S_WRI: begin
        cmd.wr_acc = 1'b1;
        cmd.i_inc  = 1'b1;
        state_nxt  = S_ICHK;
      end
      S_KRD: begin
        if (st.i_done) begin
          cmd.cnt_from_w = 1'b1;
          state_nxt      = S_EMIT1;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_KCP;
        end
      end
      S_KCP: begin
        cmd.cp    = 1'b1;
        cmd.i_inc = 1'b1;
        state_nxt = S_KRD;
      end
      S_EMIT1: begin
        if (st.out_free) begin
          cmd.out_stat = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMITF: begin
        if (st.out_free) begin
          cmd.out_full = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMITZ: begin
        if (st.out_free) begin
          cmd.out_zero = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FLRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FLEM;
      end
      S_FLEM: begin
        if (st.out_free) begin
          cmd.out_ent = 1'b1;
          cmd.i_inc   = 1'b1;
          if (st.ent_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FLRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end
endmodule
`default_nettype wire

[src/drt_dp.sv]
// drt_dp: datapath with region table RAM, live bits, counters, merge
// accumulator and output register. Depends on drt_pkg and drt_ram.
`default_nettype none
module drt_dp import drt_pkg::*; #(
  parameter int REGIONS    = 64,
  parameter int COORD_BITS = 12
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire drt_cmd_t                                cmd,
  output drt_stat_t                                    st,
  input  wire logic                                    in_accept,
  input  wire logic [1:0]                              in_op,
  input  wire logic [4*COORD_BITS-1:0]                 in_rect,
  input  wire logic                                    cfg_we,
  input  wire logic                                    cfg_addr,
  input  wire logic [SIZE_W-1:0]                       cfg_wdata,
  output logic                                         out_valid_r,
  input  wire logic                                    out_ready,
  output logic                                         out_last_r,
  output logic                                         out_rv_r,
  output logic [((4*COORD_BITS+14+7)/8)*8-1:0]         out_data_r
);
  localparam int CB    = COORD_BITS;
  localparam int RW    = 4 * CB;
  localparam int IDX_W = $clog2(REGIONS);
  localparam int CNT_W = $clog2(REGIONS + 1);
  localparam int OUT_W = ((4 * CB + 14 + 7) / 8) * 8;
  localparam int EW    = ((CB > SIZE_W) ? CB : SIZE_W) + 1;
  localparam logic [EW-1:0] CMAX = EW'((1 << CB) - 1);
  localparam logic [CNT_W-1:0] MSAT = CNT_W'((REGIONS - 1 > 63) ? 63 : REGIONS - 1);

  typedef struct packed {
    logic [CB-1:0] y2;
    logic [CB-1:0] x2;
    logic [CB-1:0] y1;
    logic [CB-1:0] x1;
  } rect_t;

  logic [SIZE_W-1:0] width_r, height_r;
  op_t               op_r;
  rect_t             rect_r, acc_r;
  logic              flag_r;
  logic [CNT_W-1:0]  cnt_r, i_r, j_r, w_r, merges_r;
  logic [REGIONS-1:0] live_r;

  logic [CB-1:0] bx, by;
  rect_t         in_r, cl, rdr;
  logic [RW-1:0] rdata;
  logic          touch;

  // screen bounds: size-1, zero treated as one, saturate at coordinate max
  function automatic logic [CB-1:0] bound(input logic [SIZE_W-1:0] sz);
    logic [EW-1:0] b;
    b = (sz == '0) ? '0 : EW'(sz) - EW'(1);
    return (b > CMAX) ? CB'(CMAX) : CB'(b);
  endfunction

  function automatic logic [CB-1:0] clampc(input logic [CB-1:0] v, input logic [CB-1:0] b);
    return (v > b) ? b : v;
  endfunction

  assign bx = bound(width_r);
  assign by = bound(height_r);

  always_comb begin
    logic [CB-1:0] ax, ay, cx, cy;
    ax = clampc(in_rect[CB-1:0], bx);
    ay = clampc(in_rect[2*CB-1:CB], by);
    cx = clampc(in_rect[3*CB-1:2*CB], bx);
    cy = clampc(in_rect[4*CB-1:3*CB], by);
    in_r.x1 = (ax < cx) ? ax : cx;
    in_r.x2 = (ax < cx) ? cx : ax;
    in_r.y1 = (ay < cy) ? ay : cy;
    in_r.y2 = (ay < cy) ? cy : ay;
  end

  assign rdr = rect_t'(rdata);

  always_comb begin
    cl.x1 = clampc(rdr.x1, bx);
    cl.y1 = clampc(rdr.y1, by);
    cl.x2 = clampc(rdr.x2, bx);
    cl.y2 = clampc(rdr.y2, by);
  end

  assign touch = ({1'b0, acc_r.x1} <= {1'b0, rdr.x2} + (CB+1)'(1)) &&
                 ({1'b0, acc_r.x2} + (CB+1)'(1) >= {1'b0, rdr.x1}) &&
                 ({1'b0, acc_r.y1} <= {1'b0, rdr.y2} + (CB+1)'(1)) &&
                 ({1'b0, acc_r.y2} + (CB+1)'(1) >= {1'b0, rdr.y1});

  // table RAM: one write, one read per cycle
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0]    ram_wdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IDX_W-1:0];
    ram_wdata = rect_r;
    if (cmd.append) begin
      ram_we = 1'b1;
    end else if (cmd.wr_acc) begin
      ram_we    = 1'b1;
      ram_waddr = i_r[IDX_W-1:0];
      ram_wdata = acc_r;
    end else if (cmd.cp) begin
      ram_we    = live_r[i_r[IDX_W-1:0]];
      ram_waddr = w_r[IDX_W-1:0];
      ram_wdata = rdata;
    end
  end

  assign ram_raddr = (cmd.rsel == RSEL_J) ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];

  drt_ram #(.WIDTH(RW), .DEPTH(REGIONS)) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (cmd.rd),
    .raddr  (ram_raddr),
    .rdata_r(rdata)
  );

  always_comb begin
    st.op        = op_r;
    st.tbl_full  = (cnt_r >= CNT_W'(REGIONS));
    st.flag      = flag_r;
    st.cnt_zero  = (cnt_r == '0);
    st.i_done    = (i_r >= cnt_r);
    st.i_live    = live_r[i_r[IDX_W-1:0]];
    st.j_done    = (j_r >= cnt_r);
    st.j_live    = live_r[j_r[IDX_W-1:0]];
    st.merges_nz = (merges_r != '0);
    st.out_free  = !out_valid_r || out_ready;
    st.ent_last  = (i_r + CNT_W'(1) == cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(1920);
      height_r <= SIZE_W'(1200);
    end else if (cfg_we) begin
      if (cfg_addr) height_r <= cfg_wdata;
      else          width_r  <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= 1'b1;
      cnt_r    <= '0;
      merges_r <= '0;
      live_r   <= '0;
      i_r      <= '0;
      j_r      <= '0;
      w_r      <= '0;
      op_r     <= OP_MARK;
    end else begin
      if (in_accept) begin
        op_r     <= op_t'(in_op);
        rect_r   <= in_r;
        merges_r <= '0;
      end
      if (cmd.append) begin
        cnt_r  <= cnt_r + CNT_W'(1);
        live_r <= '1;
        i_r    <= '0;
      end
      if (cmd.set_full || cmd.flag_set) flag_r <= 1'b1;
      if (cmd.set_full || cmd.clear)    cnt_r  <= '0;
      if (cmd.clear)                    flag_r <= 1'b0;
      if (cmd.i_clr || cmd.k_start)     i_r    <= '0;
      if (cmd.k_start)                  w_r    <= '0;
      if (cmd.i_inc)                    i_r    <= i_r + CNT_W'(1);
      if (cmd.acc_ld) begin
        acc_r <= rdr;
        j_r   <= i_r + CNT_W'(1);
      end
      if (cmd.j_inc) j_r <= j_r + CNT_W'(1);
      if (cmd.merge && touch) begin
        if (rdr.x1 < acc_r.x1) acc_r.x1 <= rdr.x1;
        if (rdr.y1 < acc_r.y1) acc_r.y1 <= rdr.y1;
        if (rdr.x2 > acc_r.x2) acc_r.x2 <= rdr.x2;
        if (rdr.y2 > acc_r.y2) acc_r.y2 <= rdr.y2;
        live_r[j_r[IDX_W-1:0]] <= 1'b0;
        merges_r <= merges_r + CNT_W'(1);
      end
      if (cmd.cp && live_r[i_r[IDX_W-1:0]]) w_r <= w_r + CNT_W'(1);
      if (cmd.cnt_from_w) cnt_r <= w_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_stat || cmd.out_full || cmd.out_zero || cmd.out_ent) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_stat) begin
      out_rv_r   <= 1'b0;
      out_last_r <= 1'b1;
      out_data_r <= OUT_W'({flag_r,
                            (cnt_r > CNT_W'(127)) ? PEND_W'(127) : PEND_W'(cnt_r),
                            (merges_r > MSAT) ? MERGES_W'(MSAT) : MERGES_W'(merges_r),
                            {RW{1'b0}}});
    end else if (cmd.out_full) begin
      out_rv_r   <= 1'b1;
      out_last_r <= 1'b1;
      out_data_r <= OUT_W'({by, bx, {CB{1'b0}}, {CB{1'b0}}});
    end else if (cmd.out_zero) begin
      out_rv_r   <= 1'b0;
      out_last_r <= 1'b1;
      out_data_r <= '0;
    end else if (cmd.out_ent) begin
      out_rv_r   <= 1'b1;
      out_last_r <= st.ent_last;
      out_data_r <= OUT_W'(cl);
    end
  end
endmodule
`default_nettype wire

[src/dirty_rectangle_tracker.sv]
// Dirty rectangle tracker: a mark runs a merge pass over pairs of table entries,
// plus a compaction sweep when merges happened; a flush emits the stored
// entries one result at a time. One item is worked at a time.
// Synchronous active-low reset: empty table, full-screen flag set, 1920x1200.
`default_nettype none
module dirty_rectangle_tracker import drt_pkg::*; #(
  parameter int REGIONS    = 64,
  parameter int COORD_BITS = 12
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // corner_ax, corner_ay, corner_bx, corner_by
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]         in_tdata,
  // opcode
  input  wire logic [1:0]                                in_tuser,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  // left_x, top_y, right_x, bottom_y, merges_done, pending_count, full_pending
  output logic [((4*COORD_BITS+14+7)/8)*8-1:0]           out_tdata,
  // rect_valid
  output logic                                           out_tuser,
  output logic                                           out_tlast,
  input  wire logic                                      cfg_we,
  input  wire logic                                      cfg_addr,
  input  wire logic [SIZE_W-1:0]                         cfg_wdata
);
  drt_cmd_t  cmd;
  drt_stat_t st;
  logic      in_accept;

  assign in_accept = in_tvalid && in_tready;

  drt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .st        (st),
    .cmd       (cmd),
    .in_ready_r(in_tready)
  );

  drt_dp #(.REGIONS(REGIONS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_accept  (in_accept),
    .in_op      (in_tuser),
    .in_rect    (in_tdata[4*COORD_BITS-1:0]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_valid_r(out_tvalid),
    .out_ready  (out_tready),
    .out_last_r (out_tlast),
    .out_rv_r   (out_tuser),
    .out_data_r (out_tdata)
  );
endmodule
`default_nettype wire

[src/drt_checker.sv]
// drt_checker: port-level assertions for dirty_rectangle_tracker, bound to
// the top level below. Depends on drt_pkg.
`default_nettype none
module drt_checker import drt_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [((4*COORD_BITS+14+7)/8)*8-1:0] out_tdata,
  input wire logic                                 out_tuser,
  input wire logic                                 out_tlast
);
  localparam int RW = 4 * COORD_BITS;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("result without rectangle not last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[RW-1:0] == '0)
    else $error("result without rectangle has coordinates");

  a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[RW+MERGES_W+PEND_W:RW] == '0)
    else $error("flush result reports pending state");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind dirty_rectangle_tracker drt_checker #(.COORD_BITS(COORD_BITS)) u_drt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for dirty_rectangle_tracker (mark, full, flush, clear).
// Predicts every result from its own damage-table model; depends on drt_pkg.
module tb;
  import drt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG = 64;
  localparam int CB   = 12;
  localparam int INW  = 48;
  localparam int OUTW = 64;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    op_t        op;
    logic [11:0] ax, ay, bx, by;
  } damage_req_t;

  typedef struct packed {
    logic        rv;
    logic [11:0] l, t, r, b;
    logic        lst;
    logic [5:0]  merges;
    logic [6:0]  pend;
    logic        full;
  } damage_res_t;

  typedef struct {
    logic [11:0] x1, y1, x2, y2;
  } box_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_we = 0, cfg_addr = 0;
  logic [INW-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic in_tready, out_tvalid, out_tuser, out_tlast;
  logic [OUTW-1:0] out_tdata;

  dirty_rectangle_tracker dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // model state
  box_t        regions[NREG];
  int          reg_cnt;
  bit          full_flag;
  int          scr_w, scr_h;
  damage_req_t pending_q[$];
  damage_res_t expected_q[$];
  int errors, mismatches, results_seen, rect_results;
  int hold_cycles;
  bit hold_req;

  function automatic int bound_of(int sz);
    int b;
    b = (sz == 0) ? 0 : sz - 1;
    return (b > 4095) ? 4095 : b;
  endfunction

  function automatic logic [11:0] clampv(int v, int b);
    return (v > b) ? b[11:0] : v[11:0];
  endfunction

  function automatic damage_res_t mk(logic rv, box_t bx, logic lst, int m, int p, logic f);
    damage_res_t o;
    o.rv = rv;
    o.l = rv ? bx.x1 : '0;
    o.t = rv ? bx.y1 : '0;
    o.r = rv ? bx.x2 : '0;
    o.b = rv ? bx.y2 : '0;
    o.lst = lst;
    o.merges = (m > 63) ? 6'd63 : m[5:0];
    o.pend = (p > 127) ? 7'd127 : p[6:0];
    o.full = f;
    return o;
  endfunction

  function automatic int coalesce();
    bit live[NREG];
    int n, w, m;
    n = reg_cnt;
    m = 0;
    for (int i = 0; i < n; i++) live[i] = 1;
    for (int i = 0; i < n; i++) begin
      if (!live[i]) continue;
      for (int j = i + 1; j < n; j++) begin
        if (!live[j]) continue;
        if (int'(regions[i].x1) <= int'(regions[j].x2) + 1 &&
            int'(regions[i].x2) + 1 >= int'(regions[j].x1) &&
            int'(regions[i].y1) <= int'(regions[j].y2) + 1 &&
            int'(regions[i].y2) + 1 >= int'(regions[j].y1)) begin
          if (regions[j].x1 < regions[i].x1) regions[i].x1 = regions[j].x1;
          if (regions[j].y1 < regions[i].y1) regions[i].y1 = regions[j].y1;
          if (regions[j].x2 > regions[i].x2) regions[i].x2 = regions[j].x2;
          if (regions[j].y2 > regions[i].y2) regions[i].y2 = regions[j].y2;
          live[j] = 0;
          m++;
        end
      end
    end
    if (m > 0) begin
      w = 0;
      for (int i = 0; i < n; i++)
        if (live[i]) begin
          regions[w] = regions[i];
          w++;
        end
      reg_cnt = w;
    end
    return m;
  endfunction

  task automatic predict_damage(damage_req_t q);
    int bx, by, ax, ay, cx, cy, m;
    box_t r;
    bx = bound_of(scr_w);
    by = bound_of(scr_h);
    m = 0;
    r = '{0, 0, 0, 0};
    case (q.op)
      OP_MARK: begin
        ax = clampv(q.ax, bx); ay = clampv(q.ay, by);
        cx = clampv(q.bx, bx); cy = clampv(q.by, by);
        if (reg_cnt >= NREG) full_flag = 1;
        else begin
          r.x1 = (ax < cx) ? ax : cx; r.x2 = (ax < cx) ? cx : ax;
          r.y1 = (ay < cy) ? ay : cy; r.y2 = (ay < cy) ? cy : ay;
          regions[reg_cnt] = r;
          reg_cnt++;
          m = coalesce();
        end
        expected_q.push_back(mk(0, r, 1, m, reg_cnt, full_flag));
      end
      OP_FULL: begin
        full_flag = 1; reg_cnt = 0;
        expected_q.push_back(mk(0, r, 1, 0, 0, 1));
      end
      OP_CLEAR: begin
        full_flag = 0; reg_cnt = 0;
        expected_q.push_back(mk(0, r, 1, 0, 0, 0));
      end
      default: begin
        if (full_flag) begin
          r = '{12'd0, 12'd0, bx[11:0], by[11:0]};
          expected_q.push_back(mk(1, r, 1, 0, 0, 0));
        end else if (reg_cnt == 0) begin
          expected_q.push_back(mk(0, r, 1, 0, 0, 0));
        end else begin
          for (int i = 0; i < reg_cnt; i++) begin
            r.x1 = clampv(regions[i].x1, bx); r.y1 = clampv(regions[i].y1, by);
            r.x2 = clampv(regions[i].x2, bx); r.y2 = clampv(regions[i].y2, by);
            expected_q.push_back(mk(1, r, i == reg_cnt - 1, 0, 0, 0));
          end
        end
        full_flag = 0; reg_cnt = 0;
      end
    endcase
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_damage(pending_q.pop_front());
        in_gap = gap_len();
      end
      if (in_tvalid && !in_tready) begin
        // hold the request
      end else if (in_gap > 0 || pending_q.size() == 0 ||
                   (in_tvalid && in_tready && pending_q.size() == 0)) begin
        if (in_gap > 0) in_gap--;
        in_tvalid <= 0;
      end else begin
        in_tvalid <= 1;
        in_tuser <= pending_q[0].op;
        in_tdata <= {pending_q[0].by, pending_q[0].bx, pending_q[0].ay, pending_q[0].ax};
      end
    end
  end

  // monitor and receiver stall
  int out_gap;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        damage_res_t got, exp;
        got.rv = out_tuser;
        {got.full, got.pend, got.merges, got.b, got.r, got.t, got.l} = out_tdata[61:0];
        got.lst = out_tlast;
        results_seen++;
        if (got.rv) rect_results++;
        if (expected_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %p", got);
        end else begin
          exp = expected_q.pop_front();
          if (got !== exp) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: exp %p got %p", exp, got);
          end
        end
      end
      // arm one long stall per request
      if (hold_req && hold_cycles == 0) begin
        hold_cycles = 400;
        hold_req = 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        out_gap = gap_len();
      end
    end
  end

  function automatic damage_req_t rnd_mark(int span);
    damage_req_t q;
    int x, y;
    q.op = OP_MARK;
    x = $urandom_range(0, 4095); y = $urandom_range(0, 4095);
    if ($urandom_range(0, 3) == 0) begin
      q.ax = x; q.ay = y; q.bx = $urandom; q.by = $urandom;
    end else begin
      q.ax = x % 2000; q.ay = y % 1300;
      q.bx = q.ax + $urandom_range(0, span); q.by = q.ay + $urandom_range(0, span);
      if ($urandom_range(0, 1)) {q.ax, q.bx} = {q.bx, q.ax};
    end
    return q;
  endfunction

  function automatic damage_req_t op_only(op_t o);
    damage_req_t q;
    q = '0;
    q.op = o;
    q.ax = $urandom; q.ay = $urandom; q.bx = $urandom; q.by = $urandom;
    return q;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  task automatic write_size(logic idx, int v);
    @(posedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_WIDTH) scr_w = v & 13'h1fff; else scr_h = v & 13'h1fff;
  endtask

  int sizes_w[5] = '{1920, 1, 4096, 0, 640};
  int sizes_h[5] = '{1200, 4096, 1, 8191, 480};
  damage_req_t d;

  initial begin
    reg_cnt = 0; full_flag = 1; scr_w = 1920; scr_h = 1200;
    errors = 0; mismatches = 0; in_gap = 0; out_gap = 0; hold_cycles = 0; hold_req = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // directed: flush with flag at reset, empty flush, extremes, every op
    pending_q.push_back(op_only(OP_FLUSH));
    pending_q.push_back(op_only(OP_FLUSH));
    d = '{OP_MARK, 12'hfff, 12'hfff, 12'h000, 12'h000}; pending_q.push_back(d);
    d = '{OP_MARK, 12'd10, 12'd10, 12'd20, 12'd20}; pending_q.push_back(d);
    d = '{OP_MARK, 12'd21, 12'd5, 12'd30, 12'd9}; pending_q.push_back(d);
    d = '{OP_MARK, 12'd500, 12'd500, 12'd500, 12'd500}; pending_q.push_back(d);
    pending_q.push_back(op_only(OP_FLUSH));
    pending_q.push_back(op_only(OP_FULL));
    d = '{OP_MARK, 12'd1, 12'd2, 12'd3, 12'd4}; pending_q.push_back(d);
    pending_q.push_back(op_only(OP_FLUSH));
    d = '{OP_MARK, 12'd7, 12'd7, 12'd9, 12'd9}; pending_q.push_back(d);
    pending_q.push_back(op_only(OP_CLEAR));
    pending_q.push_back(op_only(OP_FLUSH));
    // fill the table with disjoint points, then overflow it
    for (int i = 0; i < 66; i++) begin
      d = '{OP_MARK, 12'(i * 20), 12'(i * 3 * 6), 12'(i * 20), 12'(i * 18)};
      pending_q.push_back(d);
    end
    pending_q.push_back(op_only(OP_CLEAR));
    for (int i = 0; i < 64; i++) begin
      d = '{OP_MARK, 12'(i * 30), 12'd5, 12'(i * 30), 12'd5};
      pending_q.push_back(d);
    end
    d = '{OP_MARK, 12'd0, 12'd0, 12'hfff, 12'hfff}; pending_q.push_back(d);
    pending_q.push_back(op_only(OP_FLUSH));
    wait_idle();
    for (int ph = 0; ph < 5; ph++) begin
      write_size(CFG_WIDTH, sizes_w[ph]);
      write_size(CFG_HEIGHT, sizes_h[ph]);
      if (ph == 1) begin
        // back up the output while the sender keeps offering
        hold_req = 1;
        for (int i = 0; i < 12; i++) pending_q.push_back(op_only(OP_FULL));
        while (pending_q.size() != 0) @(posedge clk);
        hold_req = 0;
      end
      for (int i = 0; i < 20; i++) begin
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) pending_q.push_back(rnd_mark($urandom_range(0, 1) ? 40 : 600));
        else if (p < 85) pending_q.push_back(op_only(OP_FLUSH));
        else if (p < 93) pending_q.push_back(op_only(OP_CLEAR));
        else pending_q.push_back(op_only(OP_FULL));
      end
      pending_q.push_back(op_only(OP_FLUSH));
      wait_idle();
    end
    $display("covered %0d results (%0d rectangles) over five screen sizes,", results_seen,
             rect_results);
    $display("including table overflow and an output stall of 400 cycles");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule

[files.f]
src/drt_pkg.sv
src/drt_ram.sv
src/drt_ctrl.sv
src/drt_dp.sv
src/dirty_rectangle_tracker.sv
src/drt_checker.sv
bench/tb.sv
